FILE: rtl/tmv_pkg.sv
`default_nettype none

package tmv_pkg;

  localparam int unsigned ROWS_DEF    = 1024;
  localparam int unsigned COLUMNS_DEF = 1024;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ROW_W    = 10;
  localparam int unsigned GROUP_W  = 8;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned COLUMN_W = 10;
  localparam int unsigned SUM_W    = 19;
  localparam int unsigned LANES    = 4;
  localparam int unsigned LANE_W   = 2;

  localparam logic [LANE_W-1:0] LAST_LANE = 2'd3;

  // Ternary weight codes, two bits per lane
  localparam logic [1:0] CODE_POS  = 2'b01;
  localparam logic [1:0] CODE_NEG  = 2'b10;
  localparam logic [1:0] CODE_MASK = 2'b11;

  typedef enum logic [OP_W-1:0] {
    OP_WR_WEIGHT = 2'd0,
    OP_WR_ACT    = 2'd1,
    OP_COMPUTE   = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic clr;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/tmv_req_if.sv
`default_nettype none

interface tmv_req_if;
  logic                         valid;
  logic                         ready;
  logic [tmv_pkg::OP_W-1:0]     op;
  logic [tmv_pkg::ROW_W-1:0]    row;
  logic [tmv_pkg::GROUP_W-1:0]  group;
  logic [tmv_pkg::DATA_W-1:0]   data;

  modport source (output valid, op, row, group, data, input ready);
  modport sink   (input valid, op, row, group, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tmv_rsp_if.sv
`default_nettype none

interface tmv_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tmv_pkg::COLUMN_W-1:0]  column;
  logic signed [tmv_pkg::SUM_W-1:0] sum;
  logic                          last;

  modport source (output valid, column, sum, last, input ready);
  modport sink   (input valid, column, sum, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/tmv_ram.sv
`default_nettype none

module tmv_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic [AddrW-1:0]                waddr_i,
  input  wire logic [tmv_pkg::DATA_W-1:0]      wdata_i,
  input  wire logic [AddrW-1:0]                raddr_i,
  output logic      [tmv_pkg::DATA_W-1:0]      rdata_o
);

  logic [tmv_pkg::DATA_W-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/tmv_mac.sv
`default_nettype none

// Four lane accumulators sharing one activation per cycle; saturated sums out.
module tmv_mac #(
  parameter int unsigned Rows = tmv_pkg::ROWS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tmv_pkg::mac_ctrl_t          ctrl_i,
  input  wire logic [tmv_pkg::DATA_W-1:0]  act_i,
  input  wire logic [tmv_pkg::DATA_W-1:0]  wbyte_i,
  output tmv_pkg::sum_t                    sum_o [tmv_pkg::LANES]
);

  localparam int unsigned RowW  = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned AccW  = RowW + 9;
  localparam int unsigned ExtW  = (AccW > tmv_pkg::SUM_W) ? AccW : tmv_pkg::SUM_W;
  localparam logic signed [ExtW-1:0] SatHi = ExtW'((2 ** (tmv_pkg::SUM_W - 1)) - 1);
  localparam logic signed [ExtW-1:0] SatLo = -ExtW'(2 ** (tmv_pkg::SUM_W - 1));

  logic signed [AccW-1:0] acc_q [tmv_pkg::LANES];
  logic signed [AccW-1:0] acc_d [tmv_pkg::LANES];
  logic signed [AccW-1:0] act_ext;

  assign act_ext = AccW'($signed(act_i));

  always_comb begin
    for (int l = 0; l < tmv_pkg::LANES; l++) begin
      logic [1:0] code;
      code = wbyte_i[2 * l +: 2] & tmv_pkg::CODE_MASK;
      acc_d[l] = acc_q[l];
      if (ctrl_i.clr) begin
        acc_d[l] = '0;
      end else if (ctrl_i.acc_en) begin
        if (code == tmv_pkg::CODE_POS) begin
          acc_d[l] = acc_q[l] + act_ext;
        end else if (code == tmv_pkg::CODE_NEG) begin
          acc_d[l] = acc_q[l] - act_ext;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < tmv_pkg::LANES; l++) begin
        acc_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < tmv_pkg::LANES; l++) begin
        acc_q[l] <= acc_d[l];
      end
    end
  end

  // Clamp to the output range; only reachable with very tall matrices
  always_comb begin
    for (int l = 0; l < tmv_pkg::LANES; l++) begin
      logic signed [ExtW-1:0] ext;
      ext = ExtW'(acc_q[l]);
      if (ext > SatHi) begin
        sum_o[l] = tmv_pkg::SUM_W'(SatHi);
      end else if (ext < SatLo) begin
        sum_o[l] = tmv_pkg::SUM_W'(SatLo);
      end else begin
        sum_o[l] = tmv_pkg::SUM_W'(ext);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ternary_weight_matvec_engine_top.sv
`default_nettype none

// Ternary-weight matrix-vector engine.
// Requests arrive on req_i (valid/ready); op selects a weight byte write
// (row, group, data), an activation write (row, data) or a compute of one
// group of four columns. Writes with row or group out of range, computes
// with group out of range and op 3 are dropped without a response.
// Write requests complete when taken. A compute request walks the rows
// (one row a cycle, four column lanes updated in parallel), drains the
// registered memory reads, then hands out the four column sums on rsp_o,
// lane 0 first, last set on lane 3.
// req_i.ready is low from the compute request until the fourth sum has been
// taken; rsp_o holds column/sum/last steady while the receiver stalls.
// After reset the block sweeps the activation store to zero, one row per
// cycle, so req_i.ready stays low until the sweep is done.
// The weight store is not cleared: compute only groups whose weights for
// every row have been written.
module ternary_weight_matvec_engine_top #(
  parameter int unsigned ROWS    = tmv_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = tmv_pkg::COLUMNS_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tmv_req_if.sink   req_i,
  tmv_rsp_if.source rsp_o
);

  localparam int unsigned GroupCount = COLUMNS / 4;
  localparam int unsigned RowIdxW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned WDepth     = ROWS * GroupCount;
  localparam int unsigned WAddrW     = (WDepth > 1) ? $clog2(WDepth) : 1;
  localparam int unsigned ExtW       = (RowIdxW > tmv_pkg::ROW_W) ? RowIdxW : tmv_pkg::ROW_W;
  localparam int unsigned CmpW       = 14;

  tmv_pkg::state_e state_q, state_d;
  logic [RowIdxW-1:0]          row_q, row_d;
  logic [WAddrW-1:0]           waddr_q, waddr_d;
  logic [tmv_pkg::GROUP_W-1:0] group_q, group_d;
  logic [tmv_pkg::LANE_W-1:0]  lane_q, lane_d;
  logic                        rd_vld_q;

  logic req_fire, rsp_fire;
  logic row_ok, group_ok;
  logic [ExtW-1:0] row_ext;
  logic last_row;

  logic                       act_we;
  logic [RowIdxW-1:0]         act_waddr;
  logic [tmv_pkg::DATA_W-1:0] act_wdata;
  logic [tmv_pkg::DATA_W-1:0] act_rdata;

  logic                       w_we;
  logic [WAddrW-1:0]          w_waddr;
  logic [tmv_pkg::DATA_W-1:0] w_rdata;

  tmv_pkg::mac_ctrl_t mac_ctrl;
  tmv_pkg::sum_t      lane_sum [tmv_pkg::LANES];

  assign req_i.ready = (state_q == tmv_pkg::ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;

  assign row_ext  = ExtW'(req_i.row);
  assign row_ok   = CmpW'(req_i.row) < CmpW'(ROWS);
  assign group_ok = CmpW'(req_i.group) < CmpW'(GroupCount);
  assign last_row = (row_q == RowIdxW'(ROWS - 1));

  // Activation store: zero sweep after reset, else single-row writes
  always_comb begin
    if (state_q == tmv_pkg::ST_CLEAR) begin
      act_we    = 1'b1;
      act_waddr = row_q;
      act_wdata = '0;
    end else begin
      act_we    = req_fire && (req_i.op == tmv_pkg::OP_WR_ACT) && row_ok;
      act_waddr = row_ext[RowIdxW-1:0];
      act_wdata = req_i.data;
    end
  end

  // Weight store is row-major: row * GroupCount + group
  assign w_we    = req_fire && (req_i.op == tmv_pkg::OP_WR_WEIGHT) && row_ok && group_ok;
  assign w_waddr = WAddrW'(32'(req_i.row) * 32'(GroupCount) + 32'(req_i.group));

  tmv_ram #(
    .Depth (ROWS)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (act_waddr),
    .wdata_i (act_wdata),
    .raddr_i (row_q),
    .rdata_o (act_rdata)
  );

  tmv_ram #(
    .Depth (WDepth)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (req_i.data),
    .raddr_i (waddr_q),
    .rdata_o (w_rdata)
  );

  // Start a fresh sum on an in-range compute; accumulate in the cycle after each read address
  assign mac_ctrl.clr    = req_fire && (req_i.op == tmv_pkg::OP_COMPUTE) && group_ok;
  assign mac_ctrl.acc_en = rd_vld_q;

  tmv_mac #(
    .Rows (ROWS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .act_i   (act_rdata),
    .wbyte_i (w_rdata),
    .sum_o   (lane_sum)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    waddr_d = waddr_q;
    group_d = group_q;
    lane_d  = lane_q;
    unique case (state_q)
      tmv_pkg::ST_CLEAR: begin
        row_d = row_q + RowIdxW'(1);
        if (last_row) begin
          row_d   = '0;
          state_d = tmv_pkg::ST_IDLE;
        end
      end
      tmv_pkg::ST_IDLE: begin
        if (mac_ctrl.clr) begin
          row_d   = '0;
          waddr_d = WAddrW'(req_i.group);
          group_d = req_i.group;
          lane_d  = '0;
          state_d = tmv_pkg::ST_RUN;
        end
      end
      tmv_pkg::ST_RUN: begin
        row_d   = row_q + RowIdxW'(1);
        waddr_d = waddr_q + WAddrW'(GroupCount);
        if (last_row) begin
          row_d   = '0;
          state_d = tmv_pkg::ST_DRAIN;
        end
      end
      tmv_pkg::ST_DRAIN: begin
        state_d = tmv_pkg::ST_EMIT;
      end
      tmv_pkg::ST_EMIT: begin
        if (rsp_fire) begin
          lane_d = lane_q + tmv_pkg::LANE_W'(1);
          if (lane_q == tmv_pkg::LAST_LANE) begin
            state_d = tmv_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = tmv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tmv_pkg::ST_CLEAR;
      row_q    <= '0;
      lane_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      lane_q   <= lane_d;
      rd_vld_q <= (state_q == tmv_pkg::ST_RUN);
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q <= waddr_d;
    group_q <= group_d;
  end

  assign rsp_o.valid  = (state_q == tmv_pkg::ST_EMIT);
  assign rsp_o.column = {group_q, lane_q};
  assign rsp_o.sum    = lane_sum[lane_q];
  assign rsp_o.last   = (lane_q == tmv_pkg::LAST_LANE);

endmodule

`default_nettype wire

FILE: test/ternary_weight_matvec_engine_checker.sv
`timescale 1ns / 1ps

// Watch both channels and keep a private copy of the activation and weight
// stores. Each in-range compute request queues four column sums; each response is
// compared field by field with the oldest queued sum.
module ternary_weight_matvec_engine_checker #(
  parameter int unsigned ROWS    = tmv_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = tmv_pkg::COLUMNS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tmv_req_if   req_i,
  tmv_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned GROUPS = COLUMNS / tmv_pkg::LANES;
  localparam int SUM_HI = (1 << (tmv_pkg::SUM_W - 1)) - 1;
  localparam int SUM_LO = -(1 << (tmv_pkg::SUM_W - 1));

  typedef struct packed {
    logic [tmv_pkg::COLUMN_W-1:0] column;
    tmv_pkg::sum_t                sum;
    logic                         last;
  } column_sum_t;

  logic [tmv_pkg::DATA_W-1:0] act_mem    [ROWS];
  logic [tmv_pkg::DATA_W-1:0] weight_mem [ROWS * GROUPS];
  column_sum_t                expected_sums [$];

  always @(posedge clk_i or negedge rst_ni) begin : watch
    column_sum_t want;
    int          acc;
    logic [1:0]  code;
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) act_mem[r] = '0;
      expected_sums.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      // compare a taken column sum with the oldest one queued
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual column %0d sum %0d last %0b",
                   $time, rsp_i.column, rsp_i.sum, rsp_i.last);
          fail_count_o++;
        end else begin
          want = expected_sums.pop_front();
          if (rsp_i.column !== want.column) begin
            $display("%0t: column mismatch, expected %0d, actual %0d",
                     $time, want.column, rsp_i.column);
            fail_count_o++;
          end
          if (rsp_i.sum !== want.sum) begin
            $display("%0t: sum mismatch on column %0d, expected %0d, actual %0d",
                     $time, want.column, want.sum, rsp_i.sum);
            fail_count_o++;
          end
          if (rsp_i.last !== want.last) begin
            $display("%0t: last mismatch on column %0d, expected %0b, actual %0b",
                     $time, want.column, want.last, rsp_i.last);
            fail_count_o++;
          end
        end
      end

      // update the stores, or work out four column sums
      if (req_i.valid && req_i.ready) begin
        case (req_i.op)
          tmv_pkg::OP_WR_WEIGHT: begin
            if (req_i.row < ROWS && req_i.group < GROUPS)
              weight_mem[req_i.row * GROUPS + req_i.group] = req_i.data;
          end
          tmv_pkg::OP_WR_ACT: begin
            if (req_i.row < ROWS) act_mem[req_i.row] = req_i.data;
          end
          tmv_pkg::OP_COMPUTE: begin
            if (req_i.group < GROUPS) begin
              for (int lane = 0; lane < tmv_pkg::LANES; lane++) begin
                acc = 0;
                for (int r = 0; r < ROWS; r++) begin
                  code = weight_mem[r * GROUPS + req_i.group][2 * lane +: 2];
                  if (code == tmv_pkg::CODE_POS) acc += $signed(act_mem[r]);
                  else if (code == tmv_pkg::CODE_NEG) acc -= $signed(act_mem[r]);
                end
                if (acc > SUM_HI) acc = SUM_HI;
                if (acc < SUM_LO) acc = SUM_LO;
                want.column = tmv_pkg::COLUMN_W'(req_i.group * tmv_pkg::LANES + lane);
                want.sum    = tmv_pkg::sum_t'(acc);
                want.last   = (tmv_pkg::LANE_W'(lane) == tmv_pkg::LAST_LANE);
                expected_sums.push_back(want);
              end
            end
          end
          default: ;
        endcase
      end
      pending_o <= expected_sums.size();
    end
  end

endmodule

FILE: test/ternary_weight_matvec_engine_top_tb.sv
`timescale 1ns / 1ps

// Drive requests into the engine, take its column sums with random stalls,
// and give the verdict from the checker's mismatch count.
module ternary_weight_matvec_engine_top_tb;

  // Keep the row count small: every compute needs a weight byte written for
  // every row of its group, so each full data set costs ROWS write requests.
  // All 256 groups stay reachable, so the group and column extremes are hit.
  localparam int unsigned ROWS    = 8;
  localparam int unsigned COLUMNS = tmv_pkg::COLUMNS_DEF;
  localparam int unsigned GROUPS  = COLUMNS / tmv_pkg::LANES;

  localparam logic [tmv_pkg::OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [tmv_pkg::DATA_W-1:0] ACT_MAX   = 8'h7F;
  localparam logic [tmv_pkg::DATA_W-1:0] ACT_MIN   = 8'h80;

  localparam int RANDOM_ITEMS   = 250;
  localparam int MAX_GAP        = 17;
  // Longest correct quiet stretch is the post-reset sweep or one compute
  // plus a full stall.
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;

  tmv_req_if req_if ();
  tmv_rsp_if rsp_if ();

  int sum_mismatches;
  int sums_outstanding;

  // When set, both sides run back to back with no idle cycles.
  bit no_idle;

  // Rows of each group whose weight byte has been written since reset;
  // a compute is only ever issued for a group with every row written.
  bit [ROWS-1:0] rows_loaded [GROUPS];
  int            loaded_groups [$];
  int            useful_items;
  int            quiet_cycles;

  ternary_weight_matvec_engine_top #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ternary_weight_matvec_engine_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (sum_mismatches),
    .pending_o    (sums_outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort when no request and no response has moved for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired after %0d idle cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: before every column sum, hold ready low for a random number
  // of cycles, then keep it high until a sum is taken.
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  // Issue one request after a random gap and return at the edge that takes
  // it. Valid is lowered only when a gap follows, so a back-to-back request
  // never sees valid dropped and raised in the same step.
  task automatic send_request(input logic [tmv_pkg::OP_W-1:0]    op,
                              input logic [tmv_pkg::ROW_W-1:0]   row,
                              input logic [tmv_pkg::GROUP_W-1:0] grp,
                              input logic [tmv_pkg::DATA_W-1:0]  data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.row   <= row;
    req_if.group <= grp;
    req_if.data  <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);

    // Track which groups are safe to compute.
    if (op == tmv_pkg::OP_WR_WEIGHT && row < ROWS && grp < GROUPS
        && !(&rows_loaded[grp])) begin
      rows_loaded[grp][row] = 1'b1;
      if (&rows_loaded[grp]) loaded_groups.push_back(grp);
    end
    // Count only requests that the engine acts on.
    if (op != OP_UNUSED && !(op != tmv_pkg::OP_COMPUTE && row >= ROWS)) useful_items++;
  endtask

  // Bias activations toward the two extremes of the signed byte.
  function automatic logic [tmv_pkg::DATA_W-1:0] pick_activation();
    case ($urandom_range(0, 3))
      0:       return ACT_MAX;
      1:       return ACT_MIN;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Well-formed pass: load a whole group, update some activations, compute.
  // A quarter of passes use one weight byte and one activation for every
  // row, which can drive the column sums to their largest magnitudes.
  task automatic load_and_compute();
    logic [tmv_pkg::GROUP_W-1:0] grp;
    logic [tmv_pkg::DATA_W-1:0]  fixed_w;
    logic [tmv_pkg::DATA_W-1:0]  fixed_a;
    bit                          uniform;
    int                          acts;
    grp     = $urandom_range(0, GROUPS - 1);
    uniform = ($urandom_range(0, 3) == 0);
    fixed_w = $urandom_range(0, 1) ? {tmv_pkg::LANES{tmv_pkg::CODE_POS}}
                                   : $urandom_range(0, 255);
    fixed_a = pick_activation();
    for (int r = 0; r < ROWS; r++)
      send_request(tmv_pkg::OP_WR_WEIGHT, r, grp, uniform ? fixed_w : $urandom_range(0, 255));
    acts = uniform ? ROWS : $urandom_range(0, ROWS);
    for (int i = 0; i < acts; i++)
      send_request(tmv_pkg::OP_WR_ACT, uniform ? i : $urandom_range(0, ROWS - 1),
                   $urandom_range(0, 255), uniform ? fixed_a : pick_activation());
    send_request(tmv_pkg::OP_COMPUTE, $urandom_range(0, 1023), grp, $urandom_range(0, 255));
  endtask

  // Noise: any op, rows often out of range, computes only on loaded groups.
  task automatic send_noise();
    logic [tmv_pkg::OP_W-1:0]    op;
    logic [tmv_pkg::ROW_W-1:0]   row;
    logic [tmv_pkg::GROUP_W-1:0] grp;
    op  = $urandom_range(0, 3);
    row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, ROWS - 1);
    grp = $urandom_range(0, 255);
    if (op == tmv_pkg::OP_COMPUTE && grp < GROUPS && !(&rows_loaded[grp]))
      grp = loaded_groups[$urandom_range(0, loaded_groups.size() - 1)];
    send_request(op, row, grp, $urandom_range(0, 255));
  endtask

  initial begin
    bit drained;
    int count;
    rst_ni        <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.op     <= tmv_pkg::OP_WR_WEIGHT;
    req_if.row    <= '0;
    req_if.group  <= '0;
    req_if.data   <= '0;
    no_idle        = 1'b0;
    drained        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Load group 0 with every code in every lane (the lane
    // codes rotate by one per row), then compute it before any activation
    // is written, so the cleared activation store must give all-zero sums.
    for (int r = 0; r < ROWS; r++)
      send_request(tmv_pkg::OP_WR_WEIGHT, r, 0, {2'(r + 3), 2'(r + 2), 2'(r + 1), 2'(r)});
    send_request(tmv_pkg::OP_COMPUTE, 0, 0, 0);

    // Activation extremes on the first and last row.
    send_request(tmv_pkg::OP_WR_ACT, 0, 0, ACT_MAX);
    send_request(tmv_pkg::OP_WR_ACT, ROWS - 1, 8'hFF, ACT_MIN);
    // Dropped requests: rows out of range and the unused op.
    send_request(tmv_pkg::OP_WR_ACT, 10'h3FF, 0, 8'hFF);
    send_request(tmv_pkg::OP_WR_WEIGHT, 10'h3FF, 5, 8'hFF);
    send_request(OP_UNUSED, 10'h3FF, 8'hFF, 8'hFF);

    // Top group: lane 0 weight +1, lanes 1 and 2 zero by both zero codes,
    // lane 3 weight -1; its columns end at the top of the column range.
    for (int r = 0; r < ROWS; r++)
      send_request(tmv_pkg::OP_WR_WEIGHT, r, GROUPS - 1,
                   {tmv_pkg::CODE_NEG, 2'b00, tmv_pkg::CODE_MASK, tmv_pkg::CODE_POS});
    send_request(tmv_pkg::OP_COMPUTE, 10'h3FF, GROUPS - 1, 8'hFF);

    // Random part: mostly whole load-and-compute passes, some partial loads
    // to random groups, some runs of three noise requests.
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);

      // Hold off once until every queued column sum has been taken.
      if (!drained && useful_items >= RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        req_if.valid <= 1'b0;
        do @(posedge clk_i); while (sums_outstanding != 0);
      end

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: load_and_compute();
        6: begin
          count = $urandom_range(1, ROWS - 1);
          for (int i = 0; i < count; i++)
            send_request(tmv_pkg::OP_WR_WEIGHT, $urandom_range(0, ROWS - 1),
                         $urandom_range(0, 255), $urandom_range(0, 255));
        end
        default: repeat (3) send_noise();
      endcase
    end

    // Drop valid, wait for the queue to drain, then give the engine time
    // to show any stray response.
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sums_outstanding != 0);
    repeat (ROWS + 10) @(posedge clk_i);

    if (sum_mismatches == 0 && sums_outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tmv_pkg.sv
rtl/tmv_req_if.sv
rtl/tmv_rsp_if.sv
rtl/tmv_ram.sv
rtl/tmv_mac.sv
rtl/ternary_weight_matvec_engine_top.sv
test/ternary_weight_matvec_engine_checker.sv
test/ternary_weight_matvec_engine_top_tb.sv
